@@ design/csdd_pkg.sv @@
// shared types and constants for the closed syncmer deque detector
package csdd_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int PTR_W       = SLOT_W + 1;
    localparam int HASH_W      = 64;
    localparam int IDX_W       = 32;
    localparam int WLEN_W      = 7;
    localparam int EWIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(8);

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic              new_sequence;
    } in_word_t;

    typedef struct packed {
        logic              is_syncmer;
        logic [HASH_W-1:0] min_hash;
        logic [IDX_W-1:0]  min_position;
    } out_word_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic              new_sequence;
        logic [EWIN_W-1:0] win;
    } job_t;

endpackage

@@ design/csdd_front.sv @@
// front end: window register, input handshake and item classification
module csdd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         hash_valid,
    output logic                         hash_ready,
    input  csdd_pkg::in_word_t           hash_word,
    input  logic                         cfg_we,
    input  logic [csdd_pkg::WLEN_W-1:0]  cfg_data,
    input  logic                         queue_full,
    output logic                         job_push,
    output csdd_pkg::job_t               job
);

    logic [csdd_pkg::WLEN_W-1:0] window_length_reg;
    logic [csdd_pkg::EWIN_W-1:0] eff_win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= csdd_pkg::WLEN_RESET;
        end
        else if (cfg_we)
        begin
            window_length_reg <= cfg_data;
        end
    end

    // zero behaves as one, large values saturate
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            eff_win = csdd_pkg::EWIN_W'(1);
        end
        else if (32'(window_length_reg) > csdd_pkg::MAX_WINDOW)
        begin
            eff_win = csdd_pkg::EWIN_W'(csdd_pkg::MAX_WINDOW);
        end
        else
        begin
            eff_win = csdd_pkg::EWIN_W'(window_length_reg);
        end
    end

    assign hash_ready       = !queue_full;
    assign job_push         = hash_valid && hash_ready;
    assign job.hash_value   = hash_word.hash_value;
    assign job.new_sequence = hash_word.new_sequence;
    assign job.win          = eff_win;

endmodule

@@ design/csdd_queue.sv @@
// short fifo between the front end and the deque engine
module csdd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  csdd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           job_valid,
    output csdd_pkg::job_t job
);

    csdd_pkg::job_t                entry_reg [csdd_pkg::QUEUE_DEPTH];
    logic [csdd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [csdd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [csdd_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    assign full      = (count_reg == csdd_pkg::QCNT_W'(csdd_pkg::QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && job_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (32'(wr_ptr_reg) == csdd_pkg::QUEUE_DEPTH - 1)
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + csdd_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            if (32'(rd_ptr_reg) == csdd_pkg::QUEUE_DEPTH - 1)
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + csdd_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + csdd_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - csdd_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ design/csdd_back.sv @@
// deque engine: front expiry, back pops, push and syncmer test
module csdd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  csdd_pkg::job_t      job,
    output logic                job_pop,
    output logic                result_valid,
    input  logic                result_ready,
    output csdd_pkg::out_word_t result_word
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FRONT  = 5'b00010,
        ST_POP    = 5'b00100,
        ST_PUSH   = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [csdd_pkg::PTR_W-1:0]     fp_reg, fp_next;
    logic [csdd_pkg::PTR_W-1:0]     bp_reg, bp_next;
    logic [csdd_pkg::PTR_W-1:0]     bp_last_next;
    logic [csdd_pkg::PTR_W-1:0]     occ;
    logic [csdd_pkg::IDX_W-1:0]     count_reg, count_next;
    logic [csdd_pkg::HASH_W-1:0]    hash_reg, hash_next;
    logic [csdd_pkg::EWIN_W-1:0]    win_reg, win_next;

    logic [csdd_pkg::HASH_W-1:0]    hash_mem [csdd_pkg::MAX_WINDOW];
    logic [csdd_pkg::IDX_W-1:0]     idx_mem  [csdd_pkg::MAX_WINDOW];
    logic [csdd_pkg::HASH_W-1:0]    rd_front_hash_reg;
    logic [csdd_pkg::IDX_W-1:0]     rd_front_idx_reg;
    logic [csdd_pkg::HASH_W-1:0]    rd_back_hash_reg;
    logic [csdd_pkg::SLOT_W-1:0]    front_slot, back_slot, wr_slot;
    logic                           wr_en;

    logic                           out_valid_reg, out_valid_next;
    csdd_pkg::out_word_t            out_word_reg, out_word_next;
    logic                           out_free;

    logic [csdd_pkg::IDX_W-1:0]     win32, first_pos, last_pos;
    logic                           full_win, hit;

    assign occ          = bp_reg - fp_reg;
    assign out_free     = !out_valid_reg || result_ready;
    assign win32        = csdd_pkg::IDX_W'(win_reg);
    assign first_pos    = count_reg - win32;
    assign last_pos     = count_reg - csdd_pkg::IDX_W'(1);
    assign full_win     = (last_pos >= (win32 - csdd_pkg::IDX_W'(1)));
    assign hit          = full_win &&
                          (rd_front_idx_reg == first_pos || rd_front_idx_reg == last_pos);

    // read addresses follow the next pointers so the registered read data lines up with the updated pointers
    assign bp_last_next = bp_next - csdd_pkg::PTR_W'(1);
    assign front_slot   = fp_next[csdd_pkg::SLOT_W-1:0];
    assign back_slot    = bp_last_next[csdd_pkg::SLOT_W-1:0];
    assign wr_slot      = bp_reg[csdd_pkg::SLOT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        fp_next        = fp_reg;
        bp_next        = bp_reg;
        count_next     = count_reg;
        hash_next      = hash_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        job_pop        = 1'b0;
        wr_en          = 1'b0;

        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    hash_next = job.hash_value;
                    win_next  = job.win;
                    if (job.new_sequence)
                    begin
                        fp_next    = '0;
                        bp_next    = '0;
                        count_next = '0;
                    end
                    state_next = ST_FRONT;
                end
            end
            ST_FRONT:
            begin
                // front entry has aged out of the window
                if (occ != '0 && (count_reg - rd_front_idx_reg) >= win32)
                    fp_next = fp_reg + csdd_pkg::PTR_W'(1);
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (occ != '0 && rd_back_hash_reg > hash_reg)
                    bp_next = bp_reg - csdd_pkg::PTR_W'(1);
                else
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // make room when still at capacity
                if (32'(occ) >= csdd_pkg::MAX_WINDOW)
                    fp_next = fp_reg + csdd_pkg::PTR_W'(1);
                wr_en      = 1'b1;
                bp_next    = bp_reg + csdd_pkg::PTR_W'(1);
                count_next = count_reg + csdd_pkg::IDX_W'(1);
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (hit)
                    begin
                        out_word_next.is_syncmer   = 1'b1;
                        out_word_next.min_hash     = rd_front_hash_reg;
                        out_word_next.min_position = rd_front_idx_reg;
                    end
                    else
                    begin
                        out_word_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fp_reg        <= '0;
            bp_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fp_reg        <= fp_next;
            bp_reg        <= bp_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        win_reg      <= win_next;
        out_word_reg <= out_word_next;
    end

    // deque store, one write and two registered reads, write data forwarded
    always_ff @(posedge clk)
    begin
        if (wr_en && front_slot == wr_slot)
        begin
            rd_front_hash_reg <= hash_reg;
            rd_front_idx_reg  <= count_reg;
        end
        else
        begin
            rd_front_hash_reg <= hash_mem[front_slot];
            rd_front_idx_reg  <= idx_mem[front_slot];
        end
        if (wr_en && back_slot == wr_slot)
            rd_back_hash_reg <= hash_reg;
        else
            rd_back_hash_reg <= hash_mem[back_slot];
        if (wr_en)
        begin
            hash_mem[wr_slot] <= hash_reg;
            idx_mem[wr_slot]  <= count_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

@@ design/closed_syncmer_deque_detector_unit.sv @@
// top level of the closed syncmer deque detector
//
//  channel   direction  handshake                      word
//  hash      in         hash_valid / hash_ready        hash_word   (in_word_t)
//  result    out        result_valid / result_ready    result_word (out_word_t)
//  cfg       in         cfg_we                         cfg_data    (window length)
//
// each item steps through the deque engine states idle, front, pop, push and result, the pop state
// repeating for each back entry it pops; pops go one a cycle through the back read port of the deque store
// each hash pops at most once over its life
// a two-word queue lets the input side run ahead while the engine or the output stalls
// the output register holds a finished word while the engine starts the next item
// reset clears pointers, index and queue at once; the deque store needs no clearing
module closed_syncmer_deque_detector_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         hash_valid,
    output logic                         hash_ready,
    input  csdd_pkg::in_word_t           hash_word,
    output logic                         result_valid,
    input  logic                         result_ready,
    output csdd_pkg::out_word_t          result_word,
    input  logic                         cfg_we,
    input  logic [csdd_pkg::WLEN_W-1:0]  cfg_data
);

    logic           queue_full;
    logic           job_push;
    csdd_pkg::job_t push_job;
    logic           job_pop;
    logic           job_valid;
    csdd_pkg::job_t job;

    csdd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_word  (hash_word),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (push_job)
    );

    csdd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .job_valid (job_valid),
        .job       (job)
    );

    csdd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

endmodule

@@ design/csdd_checker.sv @@
// port level checks for the closed syncmer deque detector, bound to the top level
module csdd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                hash_valid,
    input logic                hash_ready,
    input logic                result_valid,
    input logic                result_ready,
    input csdd_pkg::out_word_t result_word
);

    // words accepted at the input and not yet delivered
    logic [3:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = hash_valid && hash_ready;
    assign out_acc = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
            pending_next = pending_reg + 4'd1;
        else if (out_acc && !in_acc)
            pending_next = pending_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 4'd0)
        else $error("result word with no item outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("more items in flight than queue, engine and output hold");

    a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_word.is_syncmer |->
            result_word.min_hash == '0 && result_word.min_position == '0)
        else $error("non-syncmer word carries a minimum");

endmodule

bind closed_syncmer_deque_detector_unit csdd_checker u_csdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .hash_valid   (hash_valid),
    .hash_ready   (hash_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
);
